/* src/mpwi_pkg.sv */
package mpwi_pkg;

  // Fixed field widths of the stream and register interface
  localparam int FIELD_W   = 6;   // sample_row, sample_col, out_row, out_col
  localparam int DIM_W     = 7;   // plane and output size registers
  localparam int GEOM_W    = 14;  // kernel / stride / pad registers (two 7-bit halves)
  localparam int HALF_W    = 7;   // one half of a geometry register
  localparam int IDX_W     = 13;  // max_index, signed
  localparam int NUM_W     = 14;  // adaptive-bound dividend width
  localparam int RAW_W     = 15;  // signed raw window bound before clamping
  localparam int CFG_IDX_W = 3;
  localparam int LANES     = 4;   // row start, row end, column start, column end
  localparam int MAX_DIM   = 64;  // rows and columns of the plane store

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_H     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_W     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_H    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_W    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAD      = 3'd7;

  // Item kinds carried in tuser
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic [DIM_W-1:0]        dim_t;

endpackage

/* src/max_pool_2d_with_index_top.sv */
// Channel | Handshake     | tuser  | tdata or fields (from bit 0 up)
// --------+---------------+--------+------------------------------------------------------
// s_axis  | tvalid/tready | action | sample_row, sample_col, sample_value, out_row, out_col
// m_axis  | tvalid/tready | -      | max_value, max_index
// cfg     | valid/ready   | -      | cfg_index, cfg_data
//
// Load beat: written straight into the plane memory if its row and column lie in the plane.
// Query beat: one memory read per window sample, walked row by row; adaptive bounds first
// run the bit-serial divider, an empty window goes from the bound step straight to FIN,
// and an out-of-range query goes straight from idle to FIN.
// Reset (rst, synchronous) returns control to idle and the registers to their defaults.
// A stalled result holds in the output register; the next query runs, then waits in FIN.
module max_pool_2d_with_index_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample_row, sample_col, sample_value, out_row, out_col (from bit 0 up)
  input  logic [((4*mpwi_pkg::FIELD_W+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic [0:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // max_value, max_index (from bit 0 up), zero filled
  output logic [((SAMPLE_BITS+mpwi_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mpwi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpwi_pkg::GEOM_W-1:0] cfg_data
);
  import mpwi_pkg::*;

  localparam int LB     = $clog2(MAX_DIM);   // bits of one coordinate
  localparam int CW     = LB + 1;            // bits of a bound up to MAX_DIM
  localparam int AW     = 2 * LB;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int OUT_W  = ((SAMPLE_BITS + IDX_W + 7) / 8) * 8;
  localparam int F_COL  = FIELD_W;
  localparam int F_VAL  = 2 * FIELD_W;
  localparam int F_OROW = 2 * FIELD_W + SAMPLE_BITS;
  localparam int F_OCOL = F_OROW + FIELD_W;
  localparam int CNT_W  = $clog2(NUM_W);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_BOUND = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration registers
  logic              adaptive_mode;
  dim_t              in_height, in_width, out_height, out_width;
  logic [GEOM_W-1:0] kernel_size, stride_size, pad_size;

  // Control
  logic [2:0]       state;
  logic [CNT_W-1:0] div_cnt;
  logic             rd_valid;
  logic             found;
  logic             out_valid;

  // Datapath
  raw_t                          lane [LANES];
  dim_t                          rem  [LANES];
  logic [CW-1:0]                 h, w, w0, w1, h1;
  logic [IDX_W-1:0]              rd_idx;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] best;
  logic [IDX_W-1:0]              best_idx;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [IDX_W-1:0]              max_index;

  logic signed [SAMPLE_BITS-1:0] plane_mem [DEPTH];

  // Beat fields
  logic                          act;
  logic [FIELD_W-1:0]            s_row, s_col, q_row, q_col;
  logic signed [SAMPLE_BITS-1:0] s_val;

  assign act   = s_axis_tuser[0];
  assign s_row = s_axis_tdata[FIELD_W-1:0];
  assign s_col = s_axis_tdata[F_COL +: FIELD_W];
  assign s_val = s_axis_tdata[F_VAL +: SAMPLE_BITS];
  assign q_row = s_axis_tdata[F_OROW +: FIELD_W];
  assign q_col = s_axis_tdata[F_OCOL +: FIELD_W];

  // Plane sizes above the store act as the store size
  dim_t          ih7, iw7;
  logic [CW-1:0] ih, iw;
  assign ih7 = (int'(in_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : in_height;
  assign iw7 = (int'(in_width)  > MAX_DIM) ? DIM_W'(MAX_DIM) : in_width;
  assign ih  = CW'(ih7);
  assign iw  = CW'(iw7);

  logic             in_acc, load_we, query_acc, q_range_ok, out_free;
  logic [AW-1:0]    wr_addr, rd_addr;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign query_acc     = in_acc && (act == ACT_QUERY);
  assign load_we       = in_acc && (act == ACT_LOAD) &&
                         (DIM_W'(s_row) < ih7) && (DIM_W'(s_col) < iw7);
  assign q_range_ok    = (DIM_W'(q_row) < out_height) && (DIM_W'(q_col) < out_width);
  assign wr_addr       = {LB'(s_row), LB'(s_col)};
  assign rd_addr       = {h[LB-1:0], w[LB-1:0]};
  assign out_free      = !out_valid || m_axis_tready;

  // Raw window bounds at query accept: one multiplier per axis serves both modes
  dim_t                       fac_h, fac_w;
  logic [FIELD_W+DIM_W-1:0]   prod_h, prod_w;
  logic [RAW_W-1:0]           init_lo_h, init_hi_h, init_lo_w, init_hi_w;

  assign fac_h  = adaptive_mode ? ih7 : stride_size[GEOM_W-1:HALF_W];
  assign fac_w  = adaptive_mode ? iw7 : stride_size[HALF_W-1:0];
  assign prod_h = q_row * fac_h;
  assign prod_w = q_col * fac_w;

  always_comb begin
    if (adaptive_mode) begin
      // floor(p*in/out) and ceil((p+1)*in/out) dividends
      init_lo_h = RAW_W'(prod_h);
      init_hi_h = RAW_W'(prod_h) + RAW_W'(ih7) + RAW_W'(out_height) - RAW_W'(1);
      init_lo_w = RAW_W'(prod_w);
      init_hi_w = RAW_W'(prod_w) + RAW_W'(iw7) + RAW_W'(out_width) - RAW_W'(1);
    end else begin
      init_lo_h = RAW_W'(prod_h) - RAW_W'(pad_size[GEOM_W-1:HALF_W]);
      init_hi_h = init_lo_h + RAW_W'(kernel_size[GEOM_W-1:HALF_W]);
      init_lo_w = RAW_W'(prod_w) - RAW_W'(pad_size[HALF_W-1:0]);
      init_hi_w = init_lo_w + RAW_W'(kernel_size[HALF_W-1:0]);
    end
  end

  // One restoring-division step per lane per cycle
  dim_t             step_rem [LANES];
  logic [NUM_W-1:0] step_quo [LANES];

  always_comb begin
    dim_t           dvs;
    logic [DIM_W:0] tmp;
    logic           ge;
    for (int i = 0; i < LANES; i++) begin
      dvs         = (i < 2) ? out_height : out_width;
      tmp         = {rem[i], lane[i][NUM_W-1]};
      ge          = (tmp >= {1'b0, dvs});
      step_rem[i] = ge ? DIM_W'(tmp - {1'b0, dvs}) : DIM_W'(tmp);
      step_quo[i] = {lane[i][NUM_W-2:0], ge};
    end
  end

  // Clamp raw bounds to the plane
  raw_t ih_s, iw_s, lo_h, hi_h, lo_w, hi_w;
  logic empty;

  assign ih_s  = RAW_W'(ih);
  assign iw_s  = RAW_W'(iw);
  assign lo_h  = lane[0][RAW_W-1] ? '0 : lane[0];
  assign hi_h  = (lane[1] > ih_s) ? ih_s : lane[1];
  assign lo_w  = lane[2][RAW_W-1] ? '0 : lane[2];
  assign hi_w  = (lane[3] > iw_s) ? iw_s : lane[3];
  assign empty = (hi_h <= lo_h) || (hi_w <= lo_w);

  // Walk position
  logic            w_last, h_last, take;
  logic [2*CW-1:0] flat;

  assign w_last = ((w + CW'(1)) == w1);
  assign h_last = ((h + CW'(1)) == h1);
  assign flat   = h * iw + (2*CW)'(w);
  assign take   = rd_valid && (!found || (best < rd_data));

  // Plane memory: load port writes, walk port reads into a register
  always_ff @(posedge clk) begin
    if (load_we) begin
      plane_mem[wr_addr] <= s_val;
    end
    if (state == ST_WALK) begin
      rd_data <= plane_mem[rd_addr];
    end
  end

  // Control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      div_cnt       <= '0;
      rd_valid      <= 1'b0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
      adaptive_mode <= 1'b0;
      in_height     <= DIM_W'(1);
      in_width      <= DIM_W'(1);
      out_height    <= DIM_W'(1);
      out_width     <= DIM_W'(1);
      kernel_size   <= GEOM_W'(129);
      stride_size   <= GEOM_W'(129);
      pad_size      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ADAPTIVE: adaptive_mode <= cfg_data[0];
          REG_IN_H:     in_height     <= cfg_data[DIM_W-1:0];
          REG_IN_W:     in_width      <= cfg_data[DIM_W-1:0];
          REG_OUT_H:    out_height    <= cfg_data[DIM_W-1:0];
          REG_OUT_W:    out_width     <= cfg_data[DIM_W-1:0];
          REG_KERNEL:   kernel_size   <= cfg_data;
          REG_STRIDE:   stride_size   <= cfg_data;
          REG_PAD:      pad_size      <= cfg_data;
          default: ;
        endcase
      end

      rd_valid <= (state == ST_WALK);
      // In FIN a drained register is reloaded on the same edge
      if (m_axis_tvalid && m_axis_tready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        found <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (query_acc) begin
            found <= 1'b0;
            if (!q_range_ok) begin
              state <= ST_FIN;
            end else if (adaptive_mode) begin
              div_cnt <= '0;
              state   <= ST_DIV;
            end else begin
              state <= ST_BOUND;
            end
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(NUM_W - 1)) begin
            state <= ST_BOUND;
          end
        end
        ST_BOUND: begin
          state <= empty ? ST_FIN : ST_WALK;
        end
        ST_WALK: begin
          if (w_last && h_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (query_acc) begin
          lane[0] <= init_lo_h;
          lane[1] <= init_hi_h;
          lane[2] <= init_lo_w;
          lane[3] <= init_hi_w;
          for (int i = 0; i < LANES; i++) begin
            rem[i] <= '0;
          end
        end
      end
      ST_DIV: begin
        for (int i = 0; i < LANES; i++) begin
          lane[i] <= RAW_W'(step_quo[i]);
          rem[i]  <= step_rem[i];
        end
      end
      ST_BOUND: begin
        h  <= lo_h[CW-1:0];
        h1 <= hi_h[CW-1:0];
        w  <= lo_w[CW-1:0];
        w0 <= lo_w[CW-1:0];
        w1 <= hi_w[CW-1:0];
      end
      ST_WALK: begin
        rd_idx <= IDX_W'(flat);
        if (w_last) begin
          w <= w0;
          h <= h + CW'(1);
        end else begin
          w <= w + CW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          max_value <= found ? best : SAMPLE_MIN;
          max_index <= found ? best_idx : '1;
        end
      end
      default: ;
    endcase

    // First maximum wins: replace only on a strictly larger sample
    if (take) begin
      best     <= rd_data;
      best_idx <= rd_idx;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({max_index, max_value});

  a_read_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_WALK || state == ST_DRAIN))
    else $error("memory read data valid outside a window walk");

  a_walk_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (w >= w0 && w < w1 && h < h1))
    else $error("walk position left the window");

  a_found_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(found) |-> $past(rd_valid))
    else $error("maximum taken without a memory read");

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> (state != ST_IDLE))
    else $error("accepted query produced no work");

endmodule
